// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the top level RTL file of the pixel writer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked at every rising edge of clk while rst_n is high.
`define ASSERT_CLKD(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLKD(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- rtl/core/rfpw_pkg.sv -----
// Package with the panel geometry, store sizes, codes and shared types of the pixel writer.
package rfpw_pkg;

    localparam int PANEL_WIDTH  = 800;
    localparam int PANEL_HEIGHT = 600;

    localparam int MONO_STRIDE = PANEL_WIDTH / 8;
    localparam int GRAY_STRIDE = PANEL_WIDTH / 2;
    localparam int MONO_DEPTH  = ((PANEL_WIDTH + 7) / 8) * PANEL_HEIGHT;
    localparam int GRAY_DEPTH  = ((PANEL_WIDTH + 1) / 2) * PANEL_HEIGHT;

    localparam int MONO_AW = (MONO_DEPTH > 1) ? $clog2(MONO_DEPTH) : 1;
    localparam int GRAY_AW = (GRAY_DEPTH > 1) ? $clog2(GRAY_DEPTH) : 1;

    localparam int PIX_W       = 12;
    localparam int COORD_W     = 11;
    localparam int COLOR_W     = 4;
    localparam int BYTE_W      = 8;
    localparam int BYTE_ADDR_W = 18;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [COORD_W-1:0] W_LAST = COORD_W'(PANEL_WIDTH - 1);
    localparam logic [COORD_W-1:0] H_LAST = COORD_W'(PANEL_HEIGHT - 1);

    localparam logic [BYTE_W-1:0] MONO_FILL = 8'h00;
    localparam logic [BYTE_W-1:0] GRAY_FILL = 8'hFF;
    localparam logic [BYTE_W-1:0] MSB_MASK  = 8'h80;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    typedef enum logic {
        REG_ROTATION  = 1'b0,
        REG_GRAY_MODE = 1'b1
    } reg_idx_t;

    // Result of clipping and address mapping for one pixel.
    typedef struct packed {
        logic               in_panel;
        logic               gray;
        logic [GRAY_AW-1:0] addr;
        logic [2:0]         bit_sel;
        logic [COLOR_W-1:0] color;
    } map_t;

    function automatic logic [BYTE_ADDR_W-1:0] to_byte_addr(input logic [GRAY_AW-1:0] a);
        logic [GRAY_AW+BYTE_ADDR_W-1:0] wide;
        wide = {{BYTE_ADDR_W{1'b0}}, a};
        return wide[BYTE_ADDR_W-1:0];
    endfunction

endpackage

// ----- rtl/core/rfpw_map.sv -----
// Clip, rotation transform and byte address computation for one pixel.
module rfpw_map (
    input  logic signed [rfpw_pkg::PIX_W-1:0]   pixel_x,
    input  logic signed [rfpw_pkg::PIX_W-1:0]   pixel_y,
    input  logic        [rfpw_pkg::COLOR_W-1:0] pixel_color,
    input  rfpw_pkg::rot_t                      rotation,
    input  logic                                gray_mode,
    output rfpw_pkg::map_t                      map
);
    import rfpw_pkg::*;

    logic [COORD_W-1:0] xu;
    logic [COORD_W-1:0] yu;
    logic [COORD_W-1:0] cw_last;
    logic [COORD_W-1:0] ch_last;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [GRAY_AW-1:0] mono_addr;
    logic [GRAY_AW-1:0] gray_addr;

    assign xu = pixel_x[COORD_W-1:0];
    assign yu = pixel_y[COORD_W-1:0];

    // Quarter turns swap the clip extents.
    assign cw_last = rotation[0] ? H_LAST : W_LAST;
    assign ch_last = rotation[0] ? W_LAST : H_LAST;

    always_comb
    begin
        unique case (rotation)
            ROT_0:
            begin
                px = xu;
                py = yu;
            end
            ROT_90:
            begin
                px = W_LAST - yu;
                py = xu;
            end
            ROT_180:
            begin
                px = W_LAST - xu;
                py = H_LAST - yu;
            end
            ROT_270:
            begin
                px = yu;
                py = H_LAST - xu;
            end
            default:
            begin
                px = xu;
                py = yu;
            end
        endcase
    end

    assign mono_addr = GRAY_AW'(MONO_STRIDE) * GRAY_AW'(py) + GRAY_AW'(px >> 3);
    assign gray_addr = GRAY_AW'(GRAY_STRIDE) * GRAY_AW'(py) + GRAY_AW'(px >> 1);

    assign map.in_panel = !pixel_x[PIX_W-1] && !pixel_y[PIX_W-1]
                          && (xu <= cw_last) && (yu <= ch_last);
    assign map.gray     = gray_mode;
    assign map.addr     = gray_mode ? gray_addr : mono_addr;
    assign map.bit_sel  = px[2:0];
    assign map.color    = pixel_color;

endmodule

// ----- rtl/core/rotated_framebuffer_pixel_writer_unit.sv -----
// Top level of the rotated framebuffer pixel writer with its two byte stores.
//
// Each input item is one pixel write (signed column, signed row, 4-bit color) in the
// rotated frame. The item is clipped against the panel as seen at the programmed
// rotation, mapped back to panel coordinates, and stored by a read-modify-write of
// one byte: in mono mode one bit per pixel (most significant bit first, a nonzero
// color sets it), in gray mode one nibble per pixel (even column in the high nibble).
// Every item gives exactly one result item: written, the byte address and the new
// byte, or all zeros when the pixel lay outside the panel. The pipeline takes one
// item per cycle while the output is not stalled. The path is input register,
// address mapping into the store read port, then modify and write-back; the
// write-back register forwards its byte to the following item so that back-to-back
// writes to the same byte stay correct. After reset a clearing pass walks both
// stores one byte a cycle over GRAY_DEPTH bytes (240000 at an 800 by 600 panel):
// the gray store is filled with 0xFF and the mono store, over its first MONO_DEPTH
// bytes, with zeros. No item is accepted during that pass; the register port works
// as ever. Registers: rotation at byte address 0, gray_mode at byte address 4.
// Change them only while no item is in flight.
`include "assert_macros.svh"

module rotated_framebuffer_pixel_writer_unit (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Pixel input channel.
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [rfpw_pkg::PIX_W-1:0]       pixel_x,
    input  logic signed [rfpw_pkg::PIX_W-1:0]       pixel_y,
    input  logic        [rfpw_pkg::COLOR_W-1:0]     pixel_color,
    // Result channel.
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic                                    written,
    output logic        [rfpw_pkg::BYTE_ADDR_W-1:0] byte_address,
    output logic        [rfpw_pkg::BYTE_W-1:0]      byte_value,
    // Register port.
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic        [rfpw_pkg::APB_AW-1:0]      paddr,
    input  logic        [rfpw_pkg::APB_DW-1:0]      pwdata,
    output logic        [rfpw_pkg::APB_DW-1:0]      prdata,
    output logic                                    pready
);
    import rfpw_pkg::*;

    // Configuration registers.
    rot_t rotation_reg;
    logic gray_mode_reg;
    logic cfg_wr;

    // Clearing pass.
    logic               clr_active_reg;
    logic               clr_active_next;
    logic [GRAY_AW-1:0] clr_addr_reg;
    logic [GRAY_AW-1:0] clr_addr_next;

    // Pipeline control.
    logic adv;

    // Input stage.
    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    logic signed [PIX_W-1:0]   s1_x_reg;
    logic signed [PIX_W-1:0]   s1_y_reg;
    logic        [COLOR_W-1:0] s1_color_reg;
    map_t                      s1_map;

    // Modify stage.
    logic s2_valid_reg;
    map_t s2_map_reg;

    // Store arrays and their read data.
    logic [BYTE_W-1:0] mono_mem [MONO_DEPTH];
    logic [BYTE_W-1:0] gray_mem [GRAY_DEPTH];
    logic [BYTE_W-1:0] mono_rd_reg;
    logic [BYTE_W-1:0] gray_rd_reg;

    // Store write ports.
    logic               mono_we;
    logic [MONO_AW-1:0] mono_wa;
    logic [BYTE_W-1:0]  mono_wd;
    logic               gray_we;
    logic [GRAY_AW-1:0] gray_wa;
    logic [BYTE_W-1:0]  gray_wd;

    // Forwarding of the last byte written.
    logic               fwd_valid_reg;
    logic               fwd_gray_reg;
    logic [GRAY_AW-1:0] fwd_addr_reg;
    logic [BYTE_W-1:0]  fwd_data_reg;
    logic               fwd_hit;

    // Modify logic.
    logic              s2_wr;
    logic [BYTE_W-1:0] old_byte;
    logic [BYTE_W-1:0] mono_mask;
    logic [BYTE_W-1:0] new_byte;

    // Output register.
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   written_reg;
    logic [BYTE_ADDR_W-1:0] byte_address_reg;
    logic [BYTE_W-1:0]      byte_value_reg;

    // ------------------------------------------------------------------
    // Register port. Writes complete in the access phase; reads are
    // returned combinationally since pready is tied high.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg  <= ROT_0;
            gray_mode_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx_t'(paddr[2]))
                REG_ROTATION:  rotation_reg  <= rot_t'(pwdata[1:0]);
                REG_GRAY_MODE: gray_mode_reg <= pwdata[0];
                default:       rotation_reg  <= rotation_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[2]))
            REG_ROTATION:  prdata = {{(APB_DW-2){1'b0}}, rotation_reg};
            REG_GRAY_MODE: prdata = {{(APB_DW-1){1'b0}}, gray_mode_reg};
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Clearing pass. It starts at reset and covers the gray store; the
    // smaller mono store is cleared during the first part of the sweep.
    // ------------------------------------------------------------------
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            if (clr_addr_reg == GRAY_AW'(GRAY_DEPTH - 1))
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow. The whole pipeline moves together whenever the
    // output register is empty or being taken, so the store read of the
    // item in the input stage and the write of the item ahead of it
    // always fall on the same edge.
    // ------------------------------------------------------------------
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = clr_active_reg || !adv;

    assign s1_valid_next = adv ? (in_valid && !clr_active_reg) : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x_reg     <= pixel_x;
            s1_y_reg     <= pixel_y;
            s1_color_reg <= pixel_color;
            s2_map_reg   <= s1_map;
        end
    end

    // Clip, rotate and compute the byte address of the item in the input stage.
    rfpw_map u_map (
        .pixel_x     (s1_x_reg),
        .pixel_y     (s1_y_reg),
        .pixel_color (s1_color_reg),
        .rotation    (rotation_reg),
        .gray_mode   (gray_mode_reg),
        .map         (s1_map)
    );

    // ------------------------------------------------------------------
    // Stores. Both are read at the input stage address; the mode of the
    // item picks the data in the modify stage.
    // ------------------------------------------------------------------
    assign s2_wr = adv && s2_valid_reg && s2_map_reg.in_panel;

    always_comb
    begin
        if (clr_active_reg)
        begin
            mono_we = (clr_addr_reg < GRAY_AW'(MONO_DEPTH));
            mono_wa = clr_addr_reg[MONO_AW-1:0];
            mono_wd = MONO_FILL;
            gray_we = 1'b1;
            gray_wa = clr_addr_reg;
            gray_wd = GRAY_FILL;
        end
        else
        begin
            mono_we = s2_wr && !s2_map_reg.gray;
            mono_wa = s2_map_reg.addr[MONO_AW-1:0];
            mono_wd = new_byte;
            gray_we = s2_wr && s2_map_reg.gray;
            gray_wa = s2_map_reg.addr;
            gray_wd = new_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mono_we)
        begin
            mono_mem[mono_wa] <= mono_wd;
        end
        if (adv)
        begin
            mono_rd_reg <= mono_mem[s1_map.addr[MONO_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (gray_we)
        begin
            gray_mem[gray_wa] <= gray_wd;
        end
        if (adv)
        begin
            gray_rd_reg <= gray_mem[s1_map.addr];
        end
    end

    // ------------------------------------------------------------------
    // Modify stage. The store read saw the memory before the write of the
    // item just ahead, so that write is forwarded when it hit the same byte.
    // ------------------------------------------------------------------
    assign fwd_hit = fwd_valid_reg && (fwd_gray_reg == s2_map_reg.gray)
                     && (fwd_addr_reg == s2_map_reg.addr);

    always_comb
    begin
        if (fwd_hit)
        begin
            old_byte = fwd_data_reg;
        end
        else if (s2_map_reg.gray)
        begin
            old_byte = gray_rd_reg;
        end
        else
        begin
            old_byte = mono_rd_reg;
        end
    end

    assign mono_mask = MSB_MASK >> s2_map_reg.bit_sel;

    always_comb
    begin
        if (s2_map_reg.gray)
        begin
            if (s2_map_reg.bit_sel[0])
            begin
                new_byte = {old_byte[7:4], s2_map_reg.color};
            end
            else
            begin
                new_byte = {s2_map_reg.color, old_byte[3:0]};
            end
        end
        else
        begin
            new_byte = (old_byte & ~mono_mask)
                       | ((s2_map_reg.color != '0) ? mono_mask : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (s2_wr)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_wr)
        begin
            fwd_gray_reg <= s2_map_reg.gray;
            fwd_addr_reg <= s2_map_reg.addr;
            fwd_data_reg <= new_byte;
        end
    end

    // ------------------------------------------------------------------
    // Output register. A pixel outside the panel gives an all-zero item.
    // ------------------------------------------------------------------
    assign out_valid_next = adv ? s2_valid_reg : out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            written_reg      <= s2_map_reg.in_panel;
            byte_address_reg <= s2_map_reg.in_panel ? to_byte_addr(s2_map_reg.addr) : '0;
            byte_value_reg   <= s2_map_reg.in_panel ? new_byte : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign written      = written_reg;
    assign byte_address = byte_address_reg;
    assign byte_value   = byte_value_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `ASSERT_CLKD(a_clear_pipe_empty, clr_active_reg |-> !(s1_valid_reg || s2_valid_reg || out_valid_reg), "item in flight during the clearing pass")
    `ASSERT_CLKD(a_clear_ends_at_top, $fell(clr_active_reg) |-> ($past(clr_addr_reg) == GRAY_AW'(GRAY_DEPTH - 1)), "clearing pass ended early")
    `ASSERT_CLKD(a_fwd_after_clear, fwd_valid_reg |-> !clr_active_reg, "forwarded byte exists while stores are being cleared")
    `ASSERT_CLKD(a_dropped_is_zero, (out_valid_reg && !written_reg) |-> (byte_address_reg == '0 && byte_value_reg == '0), "dropped pixel gave a nonzero result")

endmodule

// ----- dv/tb_rotated_framebuffer_pixel_writer_unit.sv -----
// Self-checking testbench: directed and random pixel writes checked against a predicted byte store.
`timescale 1ns / 1ps

module tb_rotated_framebuffer_pixel_writer_unit;
    import rfpw_pkg::*;

    // Result pipeline depth of the block, plus a little slack for the pause before a register
    // write and at the end of the run.
    localparam int PIPE_LATENCY = 3;
    localparam int SETTLE_CYCLES = PIPE_LATENCY + 2;
    // The clearing pass after reset takes up most of the run, and this bound lies well
    // above the slowest run.
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 250;
    // The long receiver hold-off starts once this many results have been taken, which falls
    // in the first gray phase, where neither side idles, so the pipeline backs up fully.
    localparam int HOLD_OFF_AT = 1100;
    localparam int HOLD_OFF_CYCLES = 300;

    // One result item: written flag, byte address and the byte after the update.
    typedef struct packed {
        logic                   written;
        logic [BYTE_ADDR_W-1:0] addr;
        logic [BYTE_W-1:0]      value;
    } byte_update_t;

    // One row of the directed stimulus. The register settings travel with the row; where
    // known is set, the expected result is typed in rather than predicted.
    typedef struct {
        rot_t         rot;
        logic         gray;
        int           x;
        int           y;
        int           color;
        bit           known;
        byte_update_t want;
    } pixel_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic signed [PIX_W-1:0]   pixel_x = '0;
    logic signed [PIX_W-1:0]   pixel_y = '0;
    logic        [COLOR_W-1:0] pixel_color = '0;

    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   written;
    logic [BYTE_ADDR_W-1:0] byte_address;
    logic [BYTE_W-1:0]      byte_value;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    rotated_framebuffer_pixel_writer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_color  (pixel_color),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .written      (written),
        .byte_address (byte_address),
        .byte_value   (byte_value),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Shadow copies of the two byte stores and of the registers, as the predictor sees them.
    logic [BYTE_W-1:0] mono_bytes [MONO_DEPTH];
    logic [BYTE_W-1:0] gray_bytes [GRAY_DEPTH];
    rot_t cfg_rot = ROT_0;
    logic cfg_gray = 1'b0;

    // Byte updates that the block still owes, oldest first.
    byte_update_t expected_updates [$];
    pixel_row_t   directed_rows [$];

    int errors = 0;
    int results_seen = 0;
    int cycle_count = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    // Idle percentages of the sender and of the receiver for the current phase.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    always #4 clk = ~clk;

    // One line per mismatch; the count decides the final verdict.
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        errors++;
    endtask

    // Predicts the byte update for one pixel write at the current register settings and
    // applies it to the shadow store. A clipped pixel gives an all-zero result.
    function automatic byte_update_t paint_pixel(input logic signed [PIX_W-1:0] x,
                                                 input logic signed [PIX_W-1:0] y,
                                                 input logic [COLOR_W-1:0] color);
        int sx;
        int sy;
        int clip_w;
        int clip_h;
        int px;
        int py;
        int a;
        logic [BYTE_W-1:0] mask;
        logic [BYTE_W-1:0] v;
        byte_update_t r;
        r = '0;
        sx = x;
        sy = y;
        // Quarter and three-quarter turns swap the clip rectangle.
        clip_w = cfg_rot[0] ? PANEL_HEIGHT : PANEL_WIDTH;
        clip_h = cfg_rot[0] ? PANEL_WIDTH : PANEL_HEIGHT;
        if (sx < 0 || sy < 0 || sx >= clip_w || sy >= clip_h)
            return r;
        case (cfg_rot)
            ROT_90:  begin px = PANEL_WIDTH - 1 - sy; py = sx; end
            ROT_180: begin px = PANEL_WIDTH - 1 - sx; py = PANEL_HEIGHT - 1 - sy; end
            ROT_270: begin px = sy; py = PANEL_HEIGHT - 1 - sx; end
            default: begin px = sx; py = sy; end
        endcase
        if (!cfg_gray) begin
            // Mono: one bit per pixel, leftmost pixel in the most significant bit.
            mask = MSB_MASK >> (px % 8);
            a = (PANEL_WIDTH / 8) * py + px / 8;
            if (a >= MONO_DEPTH)
                return r;
            v = (mono_bytes[a] & ~mask) | ((color != '0) ? mask : 8'h00);
            mono_bytes[a] = v;
        end
        else begin
            // Gray: one nibble per pixel, even column in the high nibble.
            a = (PANEL_WIDTH / 2) * py + px / 2;
            if (a >= GRAY_DEPTH)
                return r;
            if (px % 2 != 0)
                v = (gray_bytes[a] & 8'hF0) | {4'h0, color};
            else
                v = (gray_bytes[a] & 8'h0F) | {color, 4'h0};
            gray_bytes[a] = v;
        end
        r.written = 1'b1;
        r.addr = BYTE_ADDR_W'(a);
        r.value = v;
        return r;
    endfunction

    task automatic add_row(input rot_t rot, input logic gray, input int x, input int y,
                           input int color, input bit known, input logic w, input int a,
                           input int v);
        pixel_row_t row;
        row.rot = rot;
        row.gray = gray;
        row.x = x;
        row.y = y;
        row.color = color;
        row.known = known;
        row.want.written = w;
        row.want.addr = BYTE_ADDR_W'(a);
        row.want.value = BYTE_W'(v);
        directed_rows.push_back(row);
    endtask

    // Offers one pixel after a random gap and returns in the time step of its acceptance.
    // The predictor runs at acceptance, so it always sees the settings the block used.
    task automatic offer_pixel(input logic signed [PIX_W-1:0] x,
                               input logic signed [PIX_W-1:0] y,
                               input logic [COLOR_W-1:0] color,
                               input bit known, input byte_update_t want);
        int gap;
        byte_update_t predicted;
        gap = 0;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_x <= x;
        pixel_y <= y;
        pixel_color <= color;
        do
            @(posedge clk);
        while (in_stall);
        predicted = paint_pixel(x, y, color);
        expected_updates.push_back(known ? want : predicted);
    endtask

    // Lowers valid and waits until every owed result has come out, then lets the pipeline
    // settle before anything touches the registers.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (expected_updates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes one register through a setup and an access phase, then reads it back. The
    // port is left idle at the end.
    task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'(4 * int'(idx));
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== data)
            report_mismatch("register readback", prdata, data);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Programs both registers; only called while the block is idle.
    task automatic set_config(input rot_t rot, input logic gray);
        write_reg(REG_ROTATION, APB_DW'(rot));
        write_reg(REG_GRAY_MODE, APB_DW'(gray));
        cfg_rot = rot;
        cfg_gray = gray;
    endtask

    // Result side: compares each taken result with the oldest owed update, then decides
    // the next stall. The long hold-off is counted here, in its own process.
    always @(posedge clk) begin : result_side
        byte_update_t want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (expected_updates.size() == 0) begin
                report_mismatch("unexpected result, written", written, 0);
            end
            else begin
                want = expected_updates.pop_front();
                if (written !== want.written)
                    report_mismatch("written", written, want.written);
                if (byte_address !== want.addr)
                    report_mismatch("byte_address", byte_address, want.addr);
                if (byte_value !== want.value)
                    report_mismatch("byte_value", byte_value, want.value);
            end
        end
        if (!hold_done && results_seen >= HOLD_OFF_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb_rotated_framebuffer_pixel_writer_unit: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int phase;
        int n;
        int r;
        int clip_w;
        int clip_h;
        int hot_x;
        int hot_y;
        int xi;
        int yi;
        byte_update_t none;
        none = '0;

        for (int i = 0; i < MONO_DEPTH; i++)
            mono_bytes[i] = MONO_FILL;
        for (int i = 0; i < GRAY_DEPTH; i++)
            gray_bytes[i] = GRAY_FILL;

        // Directed part. Mono at rotation 0 first, straight after reset: the opening and
        // closing panel pixels, clipped pixels on all four sides and a bit being cleared.
        add_row(ROT_0,   1'b0,     0,     0,  1, 1, 1'b1,     0, 8'h80);
        add_row(ROT_0,   1'b0, -2048,     0,  5, 1, 1'b0,     0, 0);
        add_row(ROT_0,   1'b0,  2047,  2047, 15, 1, 1'b0,     0, 0);
        add_row(ROT_0,   1'b0,   799,   599, 15, 1, 1'b1, 59999, 8'h01);
        add_row(ROT_0,   1'b0,   800,     0,  1, 1, 1'b0,     0, 0);
        add_row(ROT_0,   1'b0,     0,   600,  1, 1, 1'b0,     0, 0);
        add_row(ROT_0,   1'b0,     0,     0,  0, 1, 1'b1,     0, 8'h00);
        add_row(ROT_0,   1'b0,    -1,    -1,  3, 1, 1'b0,     0, 0);
        add_row(ROT_0,   1'b0,     1,     0,  8, 0, 1'b0,     0, 0);
        // The other three rotations in mono, corners and the swapped clip edge.
        add_row(ROT_90,  1'b0,   599,   799, 15, 0, 1'b0,     0, 0);
        add_row(ROT_90,  1'b0,   600,     0,  1, 1, 1'b0,     0, 0);
        add_row(ROT_90,  1'b0,     0,     0,  1, 0, 1'b0,     0, 0);
        add_row(ROT_180, 1'b0,     0,     0,  9, 0, 1'b0,     0, 0);
        add_row(ROT_180, 1'b0,   799,   599,  0, 0, 1'b0,     0, 0);
        add_row(ROT_270, 1'b0,     0,     0,  1, 0, 1'b0,     0, 0);
        add_row(ROT_270, 1'b0,   799,   599,  1, 0, 1'b0,     0, 0);
        add_row(ROT_270, 1'b0,   600,     0,  1, 1, 1'b0,     0, 0);
        // Gray mode over the 0xFF fill, including two nibbles of one byte back to back.
        add_row(ROT_0,   1'b1,     0,     0,  0, 1, 1'b1,     0, 8'h0F);
        add_row(ROT_0,   1'b1,     1,     0, 10, 0, 1'b0,     0, 0);
        add_row(ROT_0,   1'b1,   799,   599, 15, 1, 1'b1, 239999, 8'hFF);
        add_row(ROT_0,   1'b1, -2048, -2048,  0, 1, 1'b0,     0, 0);
        add_row(ROT_90,  1'b1,   599,   799,  5, 0, 1'b0,     0, 0);
        add_row(ROT_180, 1'b1,     0,     0,  0, 0, 1'b0,     0, 0);
        add_row(ROT_270, 1'b1,     0,     0,  7, 0, 1'b0,     0, 0);
        // Back to mono: switching modes must have left the mono store alone.
        add_row(ROT_0,   1'b0,     1,     0,  1, 0, 1'b0,     0, 0);

        // Reset once, then the clearing pass runs while the sender waits on in_stall.
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].rot != cfg_rot || directed_rows[i].gray != cfg_gray) begin
                drain_pipeline();
                set_config(directed_rows[i].rot, directed_rows[i].gray);
            end
            offer_pixel(PIX_W'(directed_rows[i].x), PIX_W'(directed_rows[i].y),
                        COLOR_W'(directed_rows[i].color), directed_rows[i].known,
                        directed_rows[i].want);
        end

        // Random part: every rotation in both modes, with the four idle patterns in turn.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_pipeline();
            set_config(rot_t'(phase % 4), logic'(phase / 4));
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            clip_w = cfg_rot[0] ? PANEL_HEIGHT : PANEL_WIDTH;
            clip_h = cfg_rot[0] ? PANEL_WIDTH : PANEL_HEIGHT;
            hot_x = $urandom_range(clip_w - 8);
            hot_y = $urandom_range(clip_h - 2);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                r = $urandom_range(99);
                if (r < 10) begin
                    // Raw noise so that every coordinate bit sees both values.
                    xi = $urandom;
                    yi = $urandom;
                end
                else if (r < 22) begin
                    // Just inside or just outside one of the four clip edges.
                    case ($urandom_range(3))
                        0: xi = -1;
                        1: xi = 0;
                        2: xi = clip_w - 1;
                        default: xi = clip_w;
                    endcase
                    yi = $urandom_range(clip_h - 1);
                    if ($urandom_range(1) != 0) begin
                        r = xi;
                        xi = yi % clip_w;
                        yi = (r == clip_w) ? clip_h : ((r == clip_w - 1) ? clip_h - 1 : r);
                    end
                end
                else if (r < 55) begin
                    // A small hot spot keeps hitting the same bytes back to back, which
                    // exercises the forwarding path of the read-modify-write.
                    if ($urandom_range(9) == 0) begin
                        hot_x = $urandom_range(clip_w - 8);
                        hot_y = $urandom_range(clip_h - 2);
                    end
                    xi = hot_x + $urandom_range(7);
                    yi = hot_y + $urandom_range(1);
                end
                else begin
                    xi = $urandom_range(clip_w - 1);
                    yi = $urandom_range(clip_h - 1);
                end
                offer_pixel(PIX_W'(xi), PIX_W'(yi), COLOR_W'($urandom), 1'b0, none);
            end
        end

        drain_pipeline();
        if (errors == 0 && expected_updates.size() == 0)
            $display("tb_rotated_framebuffer_pixel_writer_unit: PASS");
        else
            $display("tb_rotated_framebuffer_pixel_writer_unit: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/rfpw_pkg.sv
rtl/core/rfpw_map.sv
rtl/core/rotated_framebuffer_pixel_writer_unit.sv
dv/tb_rotated_framebuffer_pixel_writer_unit.sv
